// ===== design/ptl_pkg.sv =====
// ptl_pkg: shared types, constants and the glyph tables for the text layout block
// no dependencies; used by ptl_glyph, ptl_outbuf and proportional_text_layout_top
package ptl_pkg;

    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_PLAIN_LO   = 8'h20;
    localparam logic [7:0] CHAR_PLAIN_HI   = 8'h7F;
    localparam logic [7:0] CHAR_APOS       = 8'h27;
    localparam logic [7:0] CHAR_QUOTE      = 8'h22;

    localparam logic [6:0] GLYPH_BASE_IDX  = 7'd32;
    localparam int         GLYPH_COUNT     = 97;
    localparam logic [9:0] SRC_FOLD_X      = 10'd467;
    localparam logic [9:0] SRC_FOLD_STEP   = 10'd468;
    localparam logic [9:0] SRC_HALF_ROW_Y  = 10'd12;
    localparam logic [15:0] TEXT_WIDTH_MAX = 16'hFFFF;
    localparam int         LINE_PITCH      = 12;
    localparam int         TOP_INSET       = 3;

    // cumulative left edges of glyphs 32..127 in the font sheet
    localparam logic [9:0] GLYPH_EDGE [0:GLYPH_COUNT-1] = '{
        10'd0,   10'd6,   10'd10,  10'd17,  10'd26,  10'd34,  10'd44,  10'd53,
        10'd58,  10'd64,  10'd70,  10'd77,  10'd84,  10'd88,  10'd96,  10'd100,
        10'd110, 10'd118, 10'd124, 10'd132, 10'd140, 10'd148, 10'd156, 10'd164,
        10'd172, 10'd180, 10'd188, 10'd192, 10'd196, 10'd205, 10'd213, 10'd222,
        10'd230, 10'd239, 10'd249, 10'd258, 10'd266, 10'd275, 10'd283, 10'd291,
        10'd300, 10'd309, 10'd313, 10'd322, 10'd331, 10'd339, 10'd348, 10'd357,
        10'd366, 10'd375, 10'd384, 10'd393, 10'd402, 10'd410, 10'd419, 10'd429,
        10'd438, 10'd448, 10'd458, 10'd467, 10'd473, 10'd483, 10'd489, 10'd498,
        10'd507, 10'd512, 10'd520, 10'd528, 10'd535, 10'd543, 10'd551, 10'd558,
        10'd566, 10'd574, 10'd578, 10'd585, 10'd593, 10'd597, 10'd606, 10'd614,
        10'd622, 10'd630, 10'd638, 10'd645, 10'd653, 10'd661, 10'd669, 10'd677,
        10'd686, 10'd694, 10'd702, 10'd710, 10'd716, 10'd720, 10'd726, 10'd735,
        10'd742
    };

    typedef struct packed {
        logic              hit;
        logic [7:0]        accent;
        logic [7:0]        base;
        logic signed [3:0] dx;
        logic signed [3:0] dy;
    } accent_t;

    typedef struct packed {
        logic               kind;
        logic               first;
        logic signed [15:0] line_x;
        logic signed [15:0] pen_x;
        logic signed [15:0] top_y;
        logic [3:0]         color;
        logic [7:0]         char_code;
    } char_word_t;

    typedef struct packed {
        logic               is_width;
        logic [9:0]         src_x;
        logic [9:0]         src_y;
        logic [3:0]         src_w;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic [15:0]        text_width;
        logic               last;
    } blit_word_t;

    function automatic logic [9:0] glyph_edge(input logic [6:0] idx);
        logic [9:0] e;
        e = '0;
        if (idx < 7'(GLYPH_COUNT))
        begin
            e = GLYPH_EDGE[idx];
        end
        return e;
    endfunction

    // hungarian latin-2 letters: accent glyph, base letter and accent offset
    function automatic accent_t accent_of(input logic [7:0] code);
        accent_t a;
        a = '0;
        case (code)
            8'hE1:        a = '{1'b1, CHAR_APOS,  8'h61, 4'sd1,  -4'sd1};
            8'hE9:        a = '{1'b1, CHAR_APOS,  8'h65, 4'sd1,  -4'sd1};
            8'hED:        a = '{1'b1, CHAR_APOS,  8'h69, -4'sd1, -4'sd1};
            8'hF3:        a = '{1'b1, CHAR_APOS,  8'h6F, 4'sd1,  -4'sd1};
            8'hFA:        a = '{1'b1, CHAR_APOS,  8'h75, 4'sd1,  -4'sd1};
            8'hF6, 8'hF5: a = '{1'b1, CHAR_QUOTE, 8'h6F, -4'sd1, -4'sd1};
            8'hFC, 8'hFB: a = '{1'b1, CHAR_QUOTE, 8'h75, -4'sd1, -4'sd1};
            8'hC1:        a = '{1'b1, CHAR_APOS,  8'h41, 4'sd5,  -4'sd3};
            8'hC9:        a = '{1'b1, CHAR_APOS,  8'h45, 4'sd2,  -4'sd3};
            8'hCD:        a = '{1'b1, CHAR_APOS,  8'h49, 4'sd0,  -4'sd3};
            8'hD3:        a = '{1'b1, CHAR_APOS,  8'h4F, 4'sd2,  -4'sd3};
            8'hDA:        a = '{1'b1, CHAR_APOS,  8'h55, 4'sd2,  -4'sd3};
            8'hD6, 8'hD5: a = '{1'b1, CHAR_QUOTE, 8'h4F, 4'sd0,  -4'sd3};
            8'hDC, 8'hDB: a = '{1'b1, CHAR_QUOTE, 8'h55, 4'sd0,  -4'sd3};
            default:      a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/ptl_ifs.sv =====
// ptl_char_if and ptl_blit_if: valid/ready channels for character and blit words
// depends on nothing
interface ptl_char_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               first;
    logic signed [15:0] line_x;
    logic signed [15:0] pen_x;
    logic signed [15:0] top_y;
    logic [3:0]         color;
    logic [7:0]         char_code;

    modport source (output valid, kind, first, line_x, pen_x, top_y, color, char_code,
                    input ready);
    modport sink   (input valid, kind, first, line_x, pen_x, top_y, color, char_code,
                    output ready);
endinterface

interface ptl_blit_if;
    logic               valid;
    logic               ready;
    logic               is_width;
    logic [9:0]         src_x;
    logic [9:0]         src_y;
    logic [3:0]         src_w;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [15:0]        text_width;
    logic               last;

    modport source (output valid, is_width, src_x, src_y, src_w, dst_x, dst_y, text_width,
                    last, input ready);
    modport sink   (input valid, is_width, src_x, src_y, src_w, dst_x, dst_y, text_width,
                    last, output ready);
endinterface

// ===== design/ptl_glyph.sv =====
// ptl_glyph: glyph rom lookup, source rectangle in the font sheet and glyph width
// depends on ptl_pkg
module ptl_glyph
(
    input  logic [7:0] ch,
    input  logic [3:0] row,
    output logic [9:0] src_x,
    output logic [9:0] src_y,
    output logic [3:0] src_w
);

    logic [6:0] idx;
    logic [9:0] edge_lo;
    logic [9:0] edge_hi;
    logic [9:0] span;
    logic [9:0] sx0;
    logic [9:0] sy0;

    assign idx     = ch[6:0] - ptl_pkg::GLYPH_BASE_IDX;
    assign edge_lo = ptl_pkg::glyph_edge(idx);
    assign edge_hi = ptl_pkg::glyph_edge(idx + 7'd1);
    assign span    = edge_hi - edge_lo;
    assign src_w   = span[3:0];

    assign sx0 = edge_lo + 10'd1;
    // row * 24 + 1
    assign sy0 = {2'b00, row, 4'b0000} + {3'b000, row, 3'b000} + 10'd1;

    // glyphs past the fold sit on the lower half of the sheet row
    always_comb
    begin
        if (sx0 > ptl_pkg::SRC_FOLD_X)
        begin
            src_x = sx0 - ptl_pkg::SRC_FOLD_STEP;
            src_y = sy0 + ptl_pkg::SRC_HALF_ROW_Y;
        end
        else
        begin
            src_x = sx0;
            src_y = sy0;
        end
    end

endmodule

// ===== design/ptl_outbuf.sv =====
// ptl_outbuf: two-entry result buffer that loads one or two words and drains in order
// depends on ptl_pkg and ptl_blit_if
module ptl_outbuf
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [1:0]             load_cnt,
    input  ptl_pkg::blit_word_t    w0,
    input  ptl_pkg::blit_word_t    w1,
    output logic                   free,
    ptl_blit_if.source             dout
);

    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    ptl_pkg::blit_word_t slot0_reg;
    ptl_pkg::blit_word_t slot0_next;
    ptl_pkg::blit_word_t slot1_reg;
    ptl_pkg::blit_word_t slot1_next;
    logic                pop;

    assign pop  = dout.valid && dout.ready;
    assign free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = load_cnt;
            slot0_next = w0;
            slot1_next = w1;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign dout.valid      = (cnt_reg != 2'd0);
    assign dout.is_width   = slot0_reg.is_width;
    assign dout.src_x      = slot0_reg.src_x;
    assign dout.src_y      = slot0_reg.src_y;
    assign dout.src_w      = slot0_reg.src_w;
    assign dout.dst_x      = slot0_reg.dst_x;
    assign dout.dst_y      = slot0_reg.dst_y;
    assign dout.text_width = slot0_reg.text_width;
    assign dout.last       = slot0_reg.last;

endmodule

// ===== design/proportional_text_layout_top.sv =====
// proportional_text_layout_top: character input register, pen and width state,
// result composition; depends on ptl_pkg, ptl_ifs, ptl_glyph and ptl_outbuf
//
//   port      dir   word         handshake
//   char_in   sink  char word    valid/ready, taken when both high
//   blit_out  src   blit word    valid/ready, taken when both high
//
// a character is registered, then on commit it updates the pen or width state and
// loads its results into a two-word buffer; a plain character or width word moves
// one per cycle while output is ready, an accented letter loads its two blits at once.
// newlines and unknown codes in layout mode produce no word and never wait on output.
// reset clears pen, line start, sheet row, width sum and all valid flags.
// a stalled output holds the buffer; the input register then fills and ready drops.
module proportional_text_layout_top
#(
    parameter int COORD_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    ptl_char_if.sink   char_in,
    ptl_blit_if.source blit_out
);

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    ptl_pkg::char_word_t     s1_reg;
    ptl_pkg::char_word_t     s1_next;

    logic [COORD_BITS-1:0]   pen_x_reg;
    logic [COORD_BITS-1:0]   pen_x_next;
    logic [COORD_BITS-1:0]   line_x_reg;
    logic [COORD_BITS-1:0]   line_x_next;
    logic [COORD_BITS-1:0]   pen_y_reg;
    logic [COORD_BITS-1:0]   pen_y_next;
    logic [3:0]              row_reg;
    logic [3:0]              row_next;
    logic [15:0]             width_reg;
    logic [15:0]             width_next;

    logic                    in_acc;
    logic                    commit;
    logic                    buf_free;
    logic [1:0]              res_cnt;
    ptl_pkg::blit_word_t     w0;
    ptl_pkg::blit_word_t     w1;

    ptl_pkg::accent_t        acc;
    logic [7:0]              code;
    logic                    plain;
    logic                    newline;
    logic [COORD_BITS+15:0]  ext_line_x;
    logic [COORD_BITS+15:0]  ext_pen_x;
    logic [COORD_BITS+15:0]  ext_top_y;
    logic [COORD_BITS-1:0]   px;
    logic [COORD_BITS-1:0]   py;
    logic [COORD_BITS-1:0]   lsx;
    logic [3:0]              row;
    logic [COORD_BITS-1:0]   ax;
    logic [COORD_BITS-1:0]   ay;
    logic [15:0]             width_base;
    logic [3:0]              width_add;
    logic [16:0]             width_sum;
    logic [15:0]             width_sat;

    logic [7:0]              main_ch;
    logic [9:0]              main_sx;
    logic [9:0]              main_sy;
    logic [3:0]              main_w;
    logic [9:0]              acc_sx;
    logic [9:0]              acc_sy;
    logic [3:0]              acc_w;

    function automatic logic [15:0] low16(input logic [COORD_BITS-1:0] v);
        logic [COORD_BITS+15:0] t;
        t = {16'b0, v};
        return t[15:0];
    endfunction

    // input register
    assign in_acc         = char_in.valid && char_in.ready;
    assign char_in.ready  = !s1_valid_reg || commit;

    always_comb
    begin
        s1_next.kind      = char_in.kind;
        s1_next.first     = char_in.first;
        s1_next.line_x    = char_in.line_x;
        s1_next.pen_x     = char_in.pen_x;
        s1_next.top_y     = char_in.top_y;
        s1_next.color     = char_in.color;
        s1_next.char_code = char_in.char_code;
    end

    always_comb
    begin
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (commit)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // decode
    assign code    = s1_reg.char_code;
    assign acc     = ptl_pkg::accent_of(code);
    assign plain   = (code >= ptl_pkg::CHAR_PLAIN_LO) && (code <= ptl_pkg::CHAR_PLAIN_HI);
    assign newline = (code == ptl_pkg::CHAR_NEWLINE);

    // pen values seen by this word, with a string start applied
    assign ext_line_x = {{COORD_BITS{s1_reg.line_x[15]}}, s1_reg.line_x};
    assign ext_pen_x  = {{COORD_BITS{s1_reg.pen_x[15]}}, s1_reg.pen_x};
    assign ext_top_y  = {{COORD_BITS{s1_reg.top_y[15]}}, s1_reg.top_y};

    always_comb
    begin
        if (s1_reg.first)
        begin
            lsx = ext_line_x[COORD_BITS-1:0];
            px  = ext_pen_x[COORD_BITS-1:0];
            py  = ext_top_y[COORD_BITS-1:0] + COORD_BITS'(ptl_pkg::TOP_INSET);
            row = s1_reg.color;
        end
        else
        begin
            lsx = line_x_reg;
            px  = pen_x_reg;
            py  = pen_y_reg;
            row = row_reg;
        end
    end

    assign ax = px + {{(COORD_BITS-4){acc.dx[3]}}, acc.dx};
    assign ay = py + {{(COORD_BITS-4){acc.dy[3]}}, acc.dy};

    assign main_ch = plain ? code : acc.base;

    ptl_glyph u_glyph_main
    (
        .ch    (main_ch),
        .row   (row),
        .src_x (main_sx),
        .src_y (main_sy),
        .src_w (main_w)
    );

    ptl_glyph u_glyph_accent
    (
        .ch    (acc.accent),
        .row   (row),
        .src_x (acc_sx),
        .src_y (acc_sy),
        .src_w (acc_w)
    );

    // saturating width accumulation
    assign width_base = s1_reg.first ? 16'd0 : width_reg;
    assign width_add  = (plain || acc.hit) ? main_w : 4'd0;
    assign width_sum  = {1'b0, width_base} + {13'b0, width_add};
    assign width_sat  = width_sum[16] ? ptl_pkg::TEXT_WIDTH_MAX : width_sum[15:0];

    // result words
    always_comb
    begin
        w0      = '0;
        w1      = '0;
        res_cnt = 2'd0;
        if (!s1_reg.kind)
        begin
            res_cnt       = 2'd1;
            w0.is_width   = 1'b1;
            w0.text_width = width_sat;
            w0.last       = 1'b1;
        end
        else if (plain)
        begin
            res_cnt  = 2'd1;
            w0.src_x = main_sx;
            w0.src_y = main_sy;
            w0.src_w = main_w;
            w0.dst_x = low16(px);
            w0.dst_y = low16(py);
            w0.last  = 1'b1;
        end
        else if (acc.hit)
        begin
            res_cnt  = 2'd2;
            w0.src_x = acc_sx;
            w0.src_y = acc_sy;
            w0.src_w = acc_w;
            w0.dst_x = low16(ax);
            w0.dst_y = low16(ay);
            w1.src_x = main_sx;
            w1.src_y = main_sy;
            w1.src_w = main_w;
            w1.dst_x = low16(px);
            w1.dst_y = low16(py);
            w1.last  = 1'b1;
        end
    end

    assign commit = s1_valid_reg && ((res_cnt == 2'd0) || buf_free);

    // state update
    always_comb
    begin
        pen_x_next  = pen_x_reg;
        line_x_next = line_x_reg;
        pen_y_next  = pen_y_reg;
        row_next    = row_reg;
        width_next  = width_reg;
        if (commit)
        begin
            if (!s1_reg.kind)
            begin
                width_next = width_sat;
            end
            else
            begin
                line_x_next = lsx;
                row_next    = row;
                pen_x_next  = px;
                pen_y_next  = py;
                if (plain || acc.hit)
                begin
                    pen_x_next = px + COORD_BITS'(main_w);
                end
                else if (newline)
                begin
                    pen_y_next = py + COORD_BITS'(ptl_pkg::LINE_PITCH);
                    pen_x_next = lsx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pen_x_reg    <= '0;
            line_x_reg   <= '0;
            pen_y_reg    <= '0;
            row_reg      <= '0;
            width_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pen_x_reg    <= pen_x_next;
            line_x_reg   <= line_x_next;
            pen_y_reg    <= pen_y_next;
            row_reg      <= row_next;
            width_reg    <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    ptl_outbuf u_outbuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (commit && (res_cnt != 2'd0)),
        .load_cnt (res_cnt),
        .w0       (w0),
        .w1       (w1),
        .free     (buf_free),
        .dout     (blit_out)
    );

endmodule
